>>> design/rtpu_pkg.sv
// ----------------------------------------------------------------------------
// rtpu_pkg
// Shared types and codes for the RV32 trap and privilege unit.
// ----------------------------------------------------------------------------
package rtpu_pkg;

  localparam int unsigned XLEN   = 32;
  localparam int unsigned CNT_W  = 64;
  localparam int unsigned CODE_W = 5;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned LVL_W  = 2;
  localparam int unsigned CFG_IDX_W = 2;

  // Instruction outcome codes
  localparam logic [OP_W-1:0] OP_RETIRE = 3'd0;
  localparam logic [OP_W-1:0] OP_MRET   = 3'd1;
  localparam logic [OP_W-1:0] OP_SRET   = 3'd2;
  localparam logic [OP_W-1:0] OP_EXCEPT = 3'd3;
  localparam logic [OP_W-1:0] OP_INTR   = 3'd4;

  // Privilege levels
  localparam logic [LVL_W-1:0] LVL_U = 2'd0;
  localparam logic [LVL_W-1:0] LVL_S = 2'd1;
  localparam logic [LVL_W-1:0] LVL_M = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_EDELEG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MTVEC  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STVEC  = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [XLEN-1:0]   trap_pc;
    logic [CODE_W-1:0] cause_code;
    logic [LVL_W-1:0]  target_level;
  } item_t;

  typedef struct packed {
    logic [XLEN-1:0] edeleg;
    logic [XLEN-1:0] mtvec;
    logic [XLEN-1:0] stvec;
  } cfg_t;

  typedef struct packed {
    logic              redirect;
    logic [XLEN-1:0]   target_pc;
    logic [LVL_W-1:0]  priv_level;
    logic              machine_ie;
    logic              super_ie;
    logic [XLEN-1:0]   saved_epc;
    logic [XLEN-1:0]   saved_cause;
    logic [CNT_W-1:0]  retired_count;
    logic              bad_return;
  } result_t;

endpackage

>>> design/rtpu_exec.sv
// ----------------------------------------------------------------------------
// rtpu_exec
// Architectural state (level, status stack, xEPC, xCAUSE, instret) and the
// single-pass next-state and result logic for one instruction outcome.
// ----------------------------------------------------------------------------
module rtpu_exec (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             commit,
  input  rtpu_pkg::item_t  item,
  input  rtpu_pkg::cfg_t   cfg,
  output rtpu_pkg::result_t res
);
  import rtpu_pkg::*;

  logic [LVL_W-1:0] lvl_r, lvl_nxt;
  logic             mie_r, mie_nxt;
  logic             sie_r, sie_nxt;
  logic             mpie_r, mpie_nxt;
  logic             spie_r, spie_nxt;
  logic             spp_r, spp_nxt;
  logic [LVL_W-1:0] mpp_r, mpp_nxt;
  logic [XLEN-1:0]  mepc_r, mepc_nxt;
  logic [XLEN-1:0]  mcause_r, mcause_nxt;
  logic [XLEN-1:0]  sepc_r, sepc_nxt;
  logic [XLEN-1:0]  scause_r, scause_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic             take;
  logic             intr;
  logic [LVL_W-1:0] trap_lvl;
  logic [XLEN-1:0]  cause;
  logic [XLEN-1:0]  vec;
  logic [XLEN-1:0]  vec_tgt;
  logic             low_lvl;

  assign low_lvl = ~lvl_r[1];
  assign intr    = (item.op == OP_INTR);
  assign cause   = {intr, {(XLEN-CODE_W-1){1'b0}}, item.cause_code};
  assign vec     = (trap_lvl == LVL_M) ? cfg.mtvec : cfg.stvec;
  assign vec_tgt = {vec[XLEN-1:2], 2'b00} +
                   ((intr && vec[0]) ?
                    {{(XLEN-CODE_W-2){1'b0}}, item.cause_code, 2'b00} : '0);

  always_comb begin
    take     = 1'b0;
    trap_lvl = LVL_M;
    lvl_nxt    = lvl_r;
    mie_nxt    = mie_r;
    sie_nxt    = sie_r;
    mpie_nxt   = mpie_r;
    spie_nxt   = spie_r;
    spp_nxt    = spp_r;
    mpp_nxt    = mpp_r;
    mepc_nxt   = mepc_r;
    mcause_nxt = mcause_r;
    sepc_nxt   = sepc_r;
    scause_nxt = scause_r;
    cnt_nxt    = cnt_r;
    res            = '0;

    case (item.op)
      OP_RETIRE: begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      OP_MRET: begin
        if (lvl_r != LVL_M) begin
          res.bad_return = 1'b1;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          lvl_nxt   = mpp_r;
          mie_nxt   = mpie_r;
          mpie_nxt  = 1'b1;
          mpp_nxt   = LVL_U;
          res.redirect  = 1'b1;
          res.target_pc = mepc_r;
        end
      end
      OP_SRET: begin
        if (lvl_r != LVL_S) begin
          res.bad_return = 1'b1;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          lvl_nxt   = spp_r ? LVL_S : LVL_U;
          sie_nxt   = spie_r;
          spie_nxt  = 1'b1;
          spp_nxt   = 1'b0;
          res.redirect  = 1'b1;
          res.target_pc = sepc_r;
        end
      end
      OP_EXCEPT: begin
        take     = 1'b1;
        trap_lvl = (cfg.edeleg[item.cause_code] && low_lvl) ? LVL_S : LVL_M;
      end
      OP_INTR: begin
        if (item.target_level == LVL_M ||
            (item.target_level == LVL_S && low_lvl)) begin
          take     = 1'b1;
          trap_lvl = item.target_level;
        end else begin
          res.bad_return = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (take) begin
      lvl_nxt = trap_lvl;
      if (trap_lvl == LVL_M) begin
        mpie_nxt   = mie_r;
        mie_nxt    = 1'b0;
        mpp_nxt    = lvl_r;
        mepc_nxt   = item.trap_pc;
        mcause_nxt = cause;
      end else begin
        spie_nxt   = sie_r;
        sie_nxt    = 1'b0;
        spp_nxt    = lvl_r[0];
        sepc_nxt   = item.trap_pc;
        scause_nxt = cause;
      end
      res.redirect    = 1'b1;
      res.target_pc   = vec_tgt;
      res.saved_epc   = item.trap_pc;
      res.saved_cause = cause;
    end

    res.priv_level    = lvl_nxt;
    res.machine_ie    = mie_nxt;
    res.super_ie      = sie_nxt;
    res.retired_count = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_r    <= LVL_M;
      mie_r    <= 1'b0;
      sie_r    <= 1'b0;
      mpie_r   <= 1'b0;
      spie_r   <= 1'b0;
      spp_r    <= 1'b0;
      mpp_r    <= LVL_U;
      mepc_r   <= '0;
      mcause_r <= '0;
      sepc_r   <= '0;
      scause_r <= '0;
      cnt_r    <= '0;
    end else if (commit) begin
      lvl_r    <= lvl_nxt;
      mie_r    <= mie_nxt;
      sie_r    <= sie_nxt;
      mpie_r   <= mpie_nxt;
      spie_r   <= spie_nxt;
      spp_r    <= spp_nxt;
      mpp_r    <= mpp_nxt;
      mepc_r   <= mepc_nxt;
      mcause_r <= mcause_nxt;
      sepc_r   <= sepc_nxt;
      scause_r <= scause_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> design/riscv_trap_priv_unit.sv
// ----------------------------------------------------------------------------
// riscv_trap_priv_unit
// RV32 M/S/U trap and privilege unit with retired-instruction counter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_vld / in_stall): one instruction outcome per beat
//   (retire, MRET, SRET, exception, interrupt with target level).
//   Output channel (out_vld / out_stall): one result beat per input beat,
//   in order: redirect and target pc, level and interrupt enables after the
//   step, the xEPC/xCAUSE written by a trap, the 64-bit retired count and
//   the bad_return flag.
//   Config port (cfg_we / cfg_idx / cfg_wdata): 0 exception delegation,
//   1 machine vector, 2 supervisor vector; write only while idle.
//   Each input beat goes input register -> execute -> result register and
//   out_vld rises when the result register loads; throughput is one beat per
//   cycle while out_stall is low. State commits when the result register
//   loads.
//   Reset (rst_n low, synchronous) puts the unit in machine mode with all
//   status, trap registers, counter and config cleared, both channels empty.
//   When out_stall is high the result holds; one more beat can wait in the
//   input register, after which in_stall rises.
// ----------------------------------------------------------------------------
module riscv_trap_priv_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  output logic                             in_stall,
  input  logic [rtpu_pkg::OP_W-1:0]        in_op,
  input  logic [rtpu_pkg::XLEN-1:0]        in_trap_pc,
  input  logic [rtpu_pkg::CODE_W-1:0]      in_cause_code,
  input  logic [rtpu_pkg::LVL_W-1:0]       in_target_level,
  output logic                             out_vld,
  input  logic                             out_stall,
  output logic                             out_redirect,
  output logic [rtpu_pkg::XLEN-1:0]        out_target_pc,
  output logic [rtpu_pkg::LVL_W-1:0]       out_priv_level,
  output logic                             out_machine_ie,
  output logic                             out_super_ie,
  output logic [rtpu_pkg::XLEN-1:0]        out_saved_epc,
  output logic [rtpu_pkg::XLEN-1:0]        out_saved_cause,
  output logic [rtpu_pkg::CNT_W-1:0]       out_retired_count,
  output logic                             out_bad_return,
  input  logic                             cfg_we,
  input  logic [rtpu_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [rtpu_pkg::XLEN-1:0]        cfg_wdata
);
  import rtpu_pkg::*;

  logic    in_vld_r, in_vld_nxt;
  item_t   item_r;
  logic    out_vld_r, out_vld_nxt;
  result_t res_r;
  result_t res;
  cfg_t    cfg_r;
  logic    advance;
  logic    commit;
  logic    in_take;

  assign advance  = ~out_vld_r | ~out_stall;
  assign commit   = in_vld_r & advance;
  assign in_stall = in_vld_r & ~advance;
  assign in_take  = in_vld & ~in_stall;

  assign in_vld_nxt  = in_take | (in_vld_r & ~commit);
  assign out_vld_nxt = commit | (out_vld_r & out_stall);

  rtpu_exec u_exec (
    .clk    (clk),
    .rst_n  (rst_n),
    .commit (commit),
    .item   (item_r),
    .cfg    (cfg_r),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      cfg_r     <= '0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_EDELEG: cfg_r.edeleg <= cfg_wdata;
          CFG_MTVEC:  cfg_r.mtvec  <= cfg_wdata;
          CFG_STVEC:  cfg_r.stvec  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.op           <= in_op;
      item_r.trap_pc      <= in_trap_pc;
      item_r.cause_code   <= in_cause_code;
      item_r.target_level <= in_target_level;
    end
    if (commit) begin
      res_r <= res;
    end
  end

  assign out_vld           = out_vld_r;
  assign out_redirect      = res_r.redirect;
  assign out_target_pc     = res_r.target_pc;
  assign out_priv_level    = res_r.priv_level;
  assign out_machine_ie    = res_r.machine_ie;
  assign out_super_ie      = res_r.super_ie;
  assign out_saved_epc     = res_r.saved_epc;
  assign out_saved_cause   = res_r.saved_cause;
  assign out_retired_count = res_r.retired_count;
  assign out_bad_return    = res_r.bad_return;

endmodule

>>> bench/trap_priv_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trap_priv_checker
// Tracks configuration writes and accepted outcome beats, keeps its own copy
// of privilege level, status stack, xEPC and retired count, predicts each
// result beat and compares it field by field with the unit's result beats.
// ----------------------------------------------------------------------------
module trap_priv_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_vld,
  input  logic                           in_stall,
  input  logic [rtpu_pkg::OP_W-1:0]      in_op,
  input  logic [rtpu_pkg::XLEN-1:0]      in_trap_pc,
  input  logic [rtpu_pkg::CODE_W-1:0]    in_cause_code,
  input  logic [rtpu_pkg::LVL_W-1:0]     in_target_level,
  input  logic                           out_vld,
  input  logic                           out_stall,
  input  logic                           out_redirect,
  input  logic [rtpu_pkg::XLEN-1:0]      out_target_pc,
  input  logic [rtpu_pkg::LVL_W-1:0]     out_priv_level,
  input  logic                           out_machine_ie,
  input  logic                           out_super_ie,
  input  logic [rtpu_pkg::XLEN-1:0]      out_saved_epc,
  input  logic [rtpu_pkg::XLEN-1:0]      out_saved_cause,
  input  logic [rtpu_pkg::CNT_W-1:0]     out_retired_count,
  input  logic                           out_bad_return,
  input  logic                           cfg_we,
  input  logic [rtpu_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [rtpu_pkg::XLEN-1:0]      cfg_wdata,
  output int                             mismatch_count,
  output int                             outstanding
);
  import rtpu_pkg::*;

  logic [XLEN-1:0]  deleg_mask, m_vec, s_vec;
  logic [LVL_W-1:0] hart_lvl, mpp;
  logic             mie, sie, mpie, spie, spp;
  logic [XLEN-1:0]  mepc, sepc;
  logic [CNT_W-1:0] retired;

  result_t     outcome_q[$];
  int unsigned beat_no;
  int          errs;
  int          waiting;

  assign mismatch_count = errs;
  assign outstanding    = waiting;

  initial begin
    errs    = 0;
    waiting = 0;
    beat_no = 0;
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH beat %0d: %s", beat_no, msg);
    errs++;
  endtask

  // push the status stack and return the vector address
  function automatic logic [XLEN-1:0] enter_trap(input logic [LVL_W-1:0] dest,
                                                 input logic [XLEN-1:0] pc,
                                                 input logic [CODE_W-1:0] code,
                                                 input logic intr);
    logic [XLEN-1:0] vec;
    logic [XLEN-1:0] dest_pc;
    if (dest == LVL_M) begin
      mpie = mie;
      mie  = 1'b0;
      mpp  = hart_lvl;
      mepc = pc;
      vec  = m_vec;
    end else begin
      spie = sie;
      sie  = 1'b0;
      spp  = hart_lvl[0];
      sepc = pc;
      vec  = s_vec;
    end
    dest_pc = {vec[XLEN-1:2], 2'b00};
    if (intr && vec[0]) dest_pc = dest_pc + {{(XLEN-CODE_W-2){1'b0}}, code, 2'b00};
    hart_lvl = dest;
    return dest_pc;
  endfunction

  function automatic result_t advance_hart(input logic [OP_W-1:0] op,
                                           input logic [XLEN-1:0] pc,
                                           input logic [CODE_W-1:0] code,
                                           input logic [LVL_W-1:0] tl);
    result_t          r;
    logic [LVL_W-1:0] dest;
    r = '0;
    case (op)
      OP_RETIRE: retired = retired + CNT_W'(1);
      OP_MRET: begin
        if (hart_lvl != LVL_M) begin
          r.bad_return = 1'b1;
        end else begin
          retired     = retired + CNT_W'(1);
          hart_lvl    = mpp;
          mie         = mpie;
          mpie        = 1'b1;
          mpp         = LVL_U;
          r.redirect  = 1'b1;
          r.target_pc = mepc;
        end
      end
      OP_SRET: begin
        if (hart_lvl != LVL_S) begin
          r.bad_return = 1'b1;
        end else begin
          retired     = retired + CNT_W'(1);
          hart_lvl    = spp ? LVL_S : LVL_U;
          sie         = spie;
          spie        = 1'b1;
          spp         = 1'b0;
          r.redirect  = 1'b1;
          r.target_pc = sepc;
        end
      end
      OP_EXCEPT: begin
        // delegation only lowers traps raised below machine level
        dest          = (deleg_mask[code] && hart_lvl <= LVL_S) ? LVL_S : LVL_M;
        r.target_pc   = enter_trap(dest, pc, code, 1'b0);
        r.redirect    = 1'b1;
        r.saved_epc   = pc;
        r.saved_cause = {{(XLEN-CODE_W){1'b0}}, code};
      end
      OP_INTR: begin
        if (tl == LVL_M || (tl == LVL_S && hart_lvl <= LVL_S)) begin
          r.target_pc   = enter_trap(tl, pc, code, 1'b1);
          r.redirect    = 1'b1;
          r.saved_epc   = pc;
          r.saved_cause = {1'b1, {(XLEN-CODE_W-1){1'b0}}, code};
        end else begin
          r.bad_return = 1'b1;
        end
      end
      default: ;
    endcase
    r.priv_level    = hart_lvl;
    r.machine_ie    = mie;
    r.super_ie      = sie;
    r.retired_count = retired;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    result_t want;
    if (!rst_n) begin
      deleg_mask = '0;
      m_vec      = '0;
      s_vec      = '0;
      hart_lvl   = LVL_M;
      mpp        = LVL_U;
      mie        = 1'b0;
      sie        = 1'b0;
      mpie       = 1'b0;
      spie       = 1'b0;
      spp        = 1'b0;
      mepc       = '0;
      sepc       = '0;
      retired    = '0;
      outcome_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_EDELEG: deleg_mask = cfg_wdata;
          CFG_MTVEC:  m_vec      = cfg_wdata;
          CFG_STVEC:  s_vec      = cfg_wdata;
          default: ;
        endcase
      end
      if (in_vld && !in_stall)
        outcome_q.push_back(advance_hart(in_op, in_trap_pc, in_cause_code, in_target_level));
      if (out_vld && !out_stall) begin
        beat_no++;
        if (outcome_q.size() == 0) begin
          flag_mismatch("result beat with nothing expected");
        end else begin
          want = outcome_q.pop_front();
          if (out_redirect !== want.redirect)
            flag_mismatch($sformatf("redirect got %h want %h", out_redirect, want.redirect));
          if (out_target_pc !== want.target_pc)
            flag_mismatch($sformatf("target_pc got %h want %h", out_target_pc, want.target_pc));
          if (out_priv_level !== want.priv_level)
            flag_mismatch($sformatf("priv_level got %h want %h", out_priv_level,
                                    want.priv_level));
          if (out_machine_ie !== want.machine_ie)
            flag_mismatch($sformatf("machine_ie got %h want %h", out_machine_ie,
                                    want.machine_ie));
          if (out_super_ie !== want.super_ie)
            flag_mismatch($sformatf("super_ie got %h want %h", out_super_ie, want.super_ie));
          if (out_saved_epc !== want.saved_epc)
            flag_mismatch($sformatf("saved_epc got %h want %h", out_saved_epc, want.saved_epc));
          if (out_saved_cause !== want.saved_cause)
            flag_mismatch($sformatf("saved_cause got %h want %h", out_saved_cause,
                                    want.saved_cause));
          if (out_retired_count !== want.retired_count)
            flag_mismatch($sformatf("retired_count got %h want %h", out_retired_count,
                                    want.retired_count));
          if (out_bad_return !== want.bad_return)
            flag_mismatch($sformatf("bad_return got %h want %h", out_bad_return,
                                    want.bad_return));
        end
      end
    end
    waiting <= outcome_q.size();
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives the trap and privilege unit with a directed walk through the level
// transitions and illegal requests, then random outcome beats under several
// configurations, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import rtpu_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_BEATS = 325;

  // ignored outcome codes and the reserved level
  localparam logic [OP_W-1:0]  OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0]  OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0]  OP_RSVD7 = 3'd7;
  localparam logic [LVL_W-1:0] LVL_RSVD = 2'd2;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_vld = 1'b0;
  logic                 in_stall;
  logic [OP_W-1:0]      in_op = OP_RETIRE;
  logic [XLEN-1:0]      in_trap_pc = '0;
  logic [CODE_W-1:0]    in_cause_code = '0;
  logic [LVL_W-1:0]     in_target_level = LVL_U;
  logic                 out_vld;
  logic                 out_stall = 1'b0;
  logic                 out_redirect;
  logic [XLEN-1:0]      out_target_pc;
  logic [LVL_W-1:0]     out_priv_level;
  logic                 out_machine_ie;
  logic                 out_super_ie;
  logic [XLEN-1:0]      out_saved_epc;
  logic [XLEN-1:0]      out_saved_cause;
  logic [CNT_W-1:0]     out_retired_count;
  logic                 out_bad_return;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = CFG_EDELEG;
  logic [XLEN-1:0]      cfg_wdata = '0;

  int          chk_fails;
  int          chk_pending;
  bit          calm = 1'b1;
  int unsigned cycle_no = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  riscv_trap_priv_unit u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_vld            (in_vld),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_trap_pc        (in_trap_pc),
    .in_cause_code     (in_cause_code),
    .in_target_level   (in_target_level),
    .out_vld           (out_vld),
    .out_stall         (out_stall),
    .out_redirect      (out_redirect),
    .out_target_pc     (out_target_pc),
    .out_priv_level    (out_priv_level),
    .out_machine_ie    (out_machine_ie),
    .out_super_ie      (out_super_ie),
    .out_saved_epc     (out_saved_epc),
    .out_saved_cause   (out_saved_cause),
    .out_retired_count (out_retired_count),
    .out_bad_return    (out_bad_return),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata)
  );

  trap_priv_checker u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_vld            (in_vld),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_trap_pc        (in_trap_pc),
    .in_cause_code     (in_cause_code),
    .in_target_level   (in_target_level),
    .out_vld           (out_vld),
    .out_stall         (out_stall),
    .out_redirect      (out_redirect),
    .out_target_pc     (out_target_pc),
    .out_priv_level    (out_priv_level),
    .out_machine_ie    (out_machine_ie),
    .out_super_ie      (out_super_ie),
    .out_saved_epc     (out_saved_epc),
    .out_saved_cause   (out_saved_cause),
    .out_retired_count (out_retired_count),
    .out_bad_return    (out_bad_return),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .mismatch_count    (chk_fails),
    .outstanding       (chk_pending)
  );

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (cycle_no == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned pause_len();
    return calm ? 0 : $urandom_range(0, 15);
  endfunction

  // result side: random stall after each accepted beat, none in calm stretches
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_vld && !out_stall) hold = pause_len();
      @(negedge clk);
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_beat(input logic [OP_W-1:0] op, input logic [XLEN-1:0] pc,
                           input logic [CODE_W-1:0] code, input logic [LVL_W-1:0] tl);
    int unsigned gap;
    gap = pause_len();
    if (gap != 0) begin
      @(negedge clk);
      in_vld <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_vld          <= 1'b1;
    in_op           <= op;
    in_trap_pc      <= pc;
    in_cause_code   <= code;
    in_target_level <= tl;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [XLEN-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_vld <= 1'b0;
    while (chk_pending != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned      taken;
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [LVL_W-1:0] tl;
    logic [XLEN-1:0]  deleg_val, mvec_val, svec_val;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // codes 0 and 1 delegated, machine vector wraps at the top of memory
    write_reg(CFG_EDELEG, 32'h0000_0003);
    write_reg(CFG_MTVEC, 32'hFFFF_FFFD);
    write_reg(CFG_STVEC, 32'h0000_0101);

    send_beat(OP_RETIRE, 32'h0000_0000, 5'd0, LVL_U);
    send_beat(OP_SRET,   32'h0000_0004, 5'd0, LVL_U);
    send_beat(OP_INTR,   32'h0000_0008, 5'd3, LVL_S);
    send_beat(OP_INTR,   32'h0000_000C, 5'd3, LVL_U);
    send_beat(OP_INTR,   32'h0000_0010, 5'd3, LVL_RSVD);
    send_beat(OP_RSVD5,  32'hFFFF_FFFF, 5'd31, LVL_M);
    send_beat(OP_RSVD6,  32'hFFFF_FFFF, 5'd31, LVL_M);
    send_beat(OP_RSVD7,  32'hFFFF_FFFF, 5'd31, LVL_M);
    // delegated exception while in machine mode stays at machine level
    send_beat(OP_EXCEPT, 32'hFFFF_FFFF, 5'd0, LVL_U);
    send_beat(OP_MRET,   32'h0000_0020, 5'd0, LVL_U);
    send_beat(OP_MRET,   32'h0000_0024, 5'd0, LVL_U);
    send_beat(OP_MRET,   32'h0000_0028, 5'd0, LVL_U);
    send_beat(OP_SRET,   32'h0000_002C, 5'd0, LVL_U);
    send_beat(OP_INTR,   32'h0000_0030, 5'd7, LVL_RSVD);
    send_beat(OP_EXCEPT, 32'h1234_5678, 5'd1, LVL_U);
    send_beat(OP_INTR,   32'h8765_4321, 5'd31, LVL_S);
    send_beat(OP_EXCEPT, 32'hDEAD_BEEF, 5'd31, LVL_U);
    send_beat(OP_INTR,   32'hCAFE_F00D, 5'd31, LVL_M);
    send_beat(OP_MRET,   32'h0000_0040, 5'd0, LVL_U);
    send_beat(OP_MRET,   32'h0000_0044, 5'd0, LVL_U);
    send_beat(OP_EXCEPT, 32'h0000_0048, 5'd0, LVL_U);
    send_beat(OP_SRET,   32'h0000_004C, 5'd0, LVL_U);
    send_beat(OP_EXCEPT, 32'h0000_0050, 5'd1, LVL_U);
    send_beat(OP_INTR,   32'h0000_0054, 5'd5, LVL_S);
    send_beat(OP_SRET,   32'h0000_0058, 5'd0, LVL_U);
    send_beat(OP_SRET,   32'h0000_005C, 5'd0, LVL_U);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: begin
          deleg_val = 32'hFFFF_FFFF;
          mvec_val  = 32'h0000_0000;
          svec_val  = 32'hFFFF_FFFF;
        end
        1: begin
          deleg_val = 32'h0000_0000;
          mvec_val  = 32'hFFFF_FFFF;
          svec_val  = 32'h0000_0000;
        end
        default: begin
          deleg_val = $urandom;
          mvec_val  = $urandom;
          svec_val  = $urandom;
        end
      endcase
      write_reg(CFG_EDELEG, deleg_val);
      write_reg(CFG_MTVEC, mvec_val);
      write_reg(CFG_STVEC, svec_val);

      taken = 0;
      while (taken < PHASE_BEATS) begin
        calm = ((taken / 40) % 5) == 0;
        pick = $urandom_range(0, 99);
        if (pick < 28)      op = OP_RETIRE;
        else if (pick < 43) op = OP_MRET;
        else if (pick < 58) op = OP_SRET;
        else if (pick < 73) op = OP_EXCEPT;
        else if (pick < 95) op = OP_INTR;
        else                op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
        if ($urandom_range(0, 4) != 0)
          tl = ($urandom_range(0, 1) != 0) ? LVL_M : LVL_S;
        else
          tl = ($urandom_range(0, 1) != 0) ? LVL_RSVD : LVL_U;
        send_beat(op, $urandom, CODE_W'($urandom_range(0, 31)), tl);
        taken++;
      end
      settle();
    end

    repeat (6) @(posedge clk);
    if (chk_fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/rtpu_pkg.sv
design/rtpu_exec.sv
design/riscv_trap_priv_unit.sv
bench/trap_priv_checker.sv
bench/testbench.sv
